@@ design/iel_pkg.sv @@
`timescale 1ns / 1ps

package iel_pkg;

  localparam int MAX_TEXT_LEN    = 65536;
  localparam int MAX_PAREN_DEPTH = 255;

  localparam int IDX_W = 16;
  localparam int IDX_CAP_INT = (MAX_TEXT_LEN - 1 > 65535) ? 65535 : MAX_TEXT_LEN - 1;
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_INT);

  localparam int PD_W = $clog2(MAX_PAREN_DEPTH + 1);
  localparam logic [PD_W-1:0] PD_MAX = PD_W'(MAX_PAREN_DEPTH);

  localparam int NUM_W = 31;
  localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};

  // token queue
  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);
  localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_INIT = 3'd0,
    ST_SIGN = 3'd1,
    ST_NUM  = 3'd2,
    ST_OPR  = 3'd3,
    ST_OPEN = 3'd4,
    ST_CLOS = 3'd5,
    ST_ERR  = 3'd6
  } st_t;

  typedef enum logic [2:0] {
    EV_SPACE = 3'd0,
    EV_NUM   = 3'd1,
    EV_OPEN  = 3'd2,
    EV_CLOS  = 3'd3,
    EV_SGN   = 3'd4,
    EV_OPR   = 3'd5,
    EV_FUNC  = 3'd6,
    EV_OTH   = 3'd7
  } ev_t;

  // token kinds
  localparam logic [2:0] KIND_NUM   = 3'd0;
  localparam logic [2:0] KIND_SIGN  = 3'd1;
  localparam logic [2:0] KIND_BINOP = 3'd2;
  localparam logic [2:0] KIND_FUNC  = 3'd3;
  localparam logic [2:0] KIND_PAREN = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;

  // binary operator details
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic [2:0] DET_NONE  = 3'd0;
  localparam logic [2:0] DET_MINUS = 3'd1;
  localparam logic [2:0] DET_CLOSE = 3'd1;

  // check status
  localparam logic [2:0] S_OK          = 3'd0;
  localparam logic [2:0] S_EXTRA_CLOSE = 3'd1;
  localparam logic [2:0] S_UNCLOSED    = 3'd2;
  localparam logic [2:0] S_EMPTY       = 3'd3;
  localparam logic [2:0] S_MISSING_OP  = 3'd4;
  localparam logic [2:0] S_BAD_CHAR    = 3'd5;
  localparam logic [2:0] S_ADJ_NUM     = 3'd6;

  // function ids
  localparam logic [2:0] FN_SQRT = 3'd0;
  localparam logic [2:0] FN_ROOT = 3'd1;
  localparam logic [2:0] FN_LN   = 3'd2;
  localparam logic [2:0] FN_LOG  = 3'd3;
  localparam logic [2:0] FN_EXP  = 3'd4;
  localparam logic [2:0] FN_ABS  = 3'd5;

  // name matcher states
  localparam logic [3:0] NM_NONE = 4'd0;
  localparam logic [3:0] NM_S    = 4'd1;
  localparam logic [3:0] NM_SQ   = 4'd2;
  localparam logic [3:0] NM_SQR  = 4'd3;
  localparam logic [3:0] NM_R    = 4'd4;
  localparam logic [3:0] NM_RO   = 4'd5;
  localparam logic [3:0] NM_ROO  = 4'd6;
  localparam logic [3:0] NM_L    = 4'd7;
  localparam logic [3:0] NM_LO   = 4'd8;
  localparam logic [3:0] NM_E    = 4'd9;
  localparam logic [3:0] NM_EX   = 4'd10;
  localparam logic [3:0] NM_A    = 4'd11;
  localparam logic [3:0] NM_AB   = 4'd12;

  // characters
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_Q      = 8'h71;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       token_kind;
    logic [2:0]       token_detail;
    logic [NUM_W-1:0] number_value;
    logic [2:0]       check_status;
    logic [IDX_W-1:0] error_position;
    logic             last_result;
  } out_word_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  tok0;
    out_word_t  tok1;
  } push_t;

  function automatic ev_t iel_classify(input logic [7:0] c);
    ev_t ev;
    if (c >= CH_0 && c <= CH_9) ev = EV_NUM;
    else if (c == CH_STAR || c == CH_SLASH) ev = EV_OPR;
    else if (c == CH_PLUS || c == CH_MINUS) ev = EV_SGN;
    else if (c == CH_LPAREN) ev = EV_OPEN;
    else if (c == CH_RPAREN) ev = EV_CLOS;
    else if (c == CH_SPACE) ev = EV_SPACE;
    else ev = EV_OTH;
    return ev;
  endfunction

  // rows packed with event 7 in the top field, event 0 in the bottom
  function automatic st_t iel_next(input st_t st, input ev_t ev);
    logic [23:0] row;
    case (st)
      ST_INIT: row = {ST_ERR, ST_OPR, ST_ERR, ST_SIGN, ST_CLOS, ST_OPEN, ST_NUM, ST_INIT};
      ST_SIGN: row = {ST_ERR, ST_OPR, ST_ERR, ST_ERR, ST_ERR, ST_OPEN, ST_NUM, ST_SIGN};
      ST_NUM:  row = {ST_ERR, ST_ERR, ST_OPR, ST_OPR, ST_CLOS, ST_ERR, ST_ERR, ST_NUM};
      ST_OPR:  row = {ST_ERR, ST_OPR, ST_ERR, ST_SIGN, ST_ERR, ST_OPEN, ST_NUM, ST_OPR};
      ST_OPEN: row = {ST_ERR, ST_OPR, ST_ERR, ST_SIGN, ST_CLOS, ST_OPEN, ST_NUM, ST_OPEN};
      ST_CLOS: row = {ST_ERR, ST_ERR, ST_OPR, ST_OPR, ST_CLOS, ST_ERR, ST_ERR, ST_CLOS};
      default: row = {8{ST_ERR}};
    endcase
    return st_t'(row[3*int'(ev) +: 3]);
  endfunction

  function automatic logic [2:0] iel_err(input st_t st, input ev_t ev);
    logic [23:0] row;
    case (st)
      ST_INIT: row = {S_BAD_CHAR, S_OK, S_EMPTY, S_OK, S_EXTRA_CLOSE, S_OK, S_OK, S_OK};
      ST_SIGN: row = {S_BAD_CHAR, S_OK, S_EMPTY, S_EMPTY, S_EMPTY, S_OK, S_OK, S_OK};
      ST_NUM:  row = {S_BAD_CHAR, S_MISSING_OP, S_OK, S_OK, S_OK, S_MISSING_OP, S_ADJ_NUM,
                      S_OK};
      ST_OPR:  row = {S_BAD_CHAR, S_OK, S_EMPTY, S_OK, S_EMPTY, S_OK, S_OK, S_OK};
      ST_OPEN: row = {S_BAD_CHAR, S_OK, S_EMPTY, S_OK, S_OK, S_OK, S_OK, S_OK};
      ST_CLOS: row = {S_BAD_CHAR, S_MISSING_OP, S_OK, S_OK, S_OK, S_MISSING_OP, S_MISSING_OP,
                      S_OK};
      default: row = {8{S_BAD_CHAR}};
    endcase
    return row[3*int'(ev) +: 3];
  endfunction

  // returns 0 on mismatch, 1..12 for a partial name, 16 + id for a full name
  function automatic logic [4:0] iel_name_next(input logic [3:0] m, input logic [7:0] c);
    logic [4:0] r;
    r = {1'b0, NM_NONE};
    case (m)
      NM_NONE: begin
        if (c == CH_S) r = {1'b0, NM_S};
        else if (c == CH_R) r = {1'b0, NM_R};
        else if (c == CH_L) r = {1'b0, NM_L};
        else if (c == CH_E) r = {1'b0, NM_E};
        else if (c == CH_A) r = {1'b0, NM_A};
      end
      NM_S:   if (c == CH_Q) r = {1'b0, NM_SQ};
      NM_SQ:  if (c == CH_R) r = {1'b0, NM_SQR};
      NM_SQR: if (c == CH_T) r = {2'b10, FN_SQRT};
      NM_R:   if (c == CH_O) r = {1'b0, NM_RO};
      NM_RO:  if (c == CH_O) r = {1'b0, NM_ROO};
      NM_ROO: if (c == CH_T) r = {2'b10, FN_ROOT};
      NM_L: begin
        if (c == CH_N) r = {2'b10, FN_LN};
        else if (c == CH_O) r = {1'b0, NM_LO};
      end
      NM_LO:  if (c == CH_G) r = {2'b10, FN_LOG};
      NM_E:   if (c == CH_X) r = {1'b0, NM_EX};
      NM_EX:  if (c == CH_P) r = {2'b10, FN_EXP};
      NM_A:   if (c == CH_B) r = {1'b0, NM_AB};
      NM_AB:  if (c == CH_S) r = {2'b10, FN_ABS};
      default: r = {1'b0, NM_NONE};
    endcase
    return r;
  endfunction

  function automatic out_word_t iel_tok(input logic [2:0] kind, input logic [2:0] detail,
                                        input logic [NUM_W-1:0] value);
    out_word_t t;
    t = '0;
    t.token_kind   = kind;
    t.token_detail = detail;
    t.number_value = value;
    return t;
  endfunction

endpackage

@@ design/iel_lexer.sv @@
`timescale 1ns / 1ps

module iel_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  iel_pkg::in_word_t in_word,
  output iel_pkg::push_t    push
);
  import iel_pkg::*;

  st_t              parse_state_r, parse_state_nxt;
  logic [PD_W-1:0]  paren_depth_r, paren_depth_nxt;
  logic [NUM_W-1:0] number_accum_r, number_accum_nxt;
  logic             number_pending_r, number_pending_nxt;
  logic [3:0]       name_match_r, name_match_nxt;
  logic [IDX_W-1:0] char_index_r, char_index_nxt;
  logic [2:0]       error_code_r, error_code_nxt;
  logic [IDX_W-1:0] error_index_r, error_index_nxt;
  logic             halted_r, halted_nxt;

  logic [7:0]       c;
  logic             eot;
  ev_t              ev;
  st_t              ns;
  logic [2:0]       e;
  logic [4:0]       nm;
  logic [2:0]       fid;
  logic             apply_go;
  logic             do_fail;
  logic [2:0]       f_code;
  logic [IDX_W-1:0] f_pos;
  logic             emit_a;
  out_word_t        tok_a;
  out_word_t        tok_end;
  out_word_t        tok0, tok1;
  logic [1:0]       n;
  logic [NUM_W+3:0] acc_wide;
  logic [NUM_W-1:0] acc_sat;
  logic [2:0]       op_det;

  assign c   = in_word.char_code;
  assign eot = in_word.end_of_text;

  // accum * 10 + digit, saturating
  assign acc_wide = (NUM_W+4)'({number_accum_r, 3'b000}) + (NUM_W+4)'({number_accum_r, 1'b0})
                  + (NUM_W+4)'(c[3:0]);
  assign acc_sat  = (acc_wide > (NUM_W+4)'(NUM_SAT)) ? NUM_SAT : acc_wide[NUM_W-1:0];

  assign op_det = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
                  (c == CH_STAR) ? OP_MUL : OP_DIV;

  always_comb begin
    parse_state_nxt    = parse_state_r;
    paren_depth_nxt    = paren_depth_r;
    number_accum_nxt   = number_accum_r;
    number_pending_nxt = number_pending_r;
    name_match_nxt     = name_match_r;
    char_index_nxt     = char_index_r;
    error_code_nxt     = error_code_r;
    error_index_nxt    = error_index_r;
    halted_nxt         = halted_r;

    tok0     = '0;
    tok1     = '0;
    tok_a    = '0;
    tok_end  = '0;
    emit_a   = 1'b0;
    n        = 2'd0;
    apply_go = 1'b0;
    do_fail  = 1'b0;
    f_code   = S_OK;
    f_pos    = '0;
    fid      = FN_SQRT;
    ev       = iel_classify(c);
    nm       = iel_name_next(name_match_r, c);
    ns       = ST_ERR;
    e        = S_OK;

    if (step && !halted_r) begin
      if (char_index_r < IDX_CAP) char_index_nxt = char_index_r + IDX_W'(1);

      if (name_match_r != NM_NONE) begin
        if (nm == 5'd0) begin
          do_fail = 1'b1;
          f_code  = S_BAD_CHAR;
          f_pos   = error_index_r;
        end else if (nm[4]) begin
          name_match_nxt = NM_NONE;
          ev             = EV_FUNC;
          fid            = nm[2:0];
          apply_go       = 1'b1;
        end else begin
          name_match_nxt = nm[3:0];
        end
      end else begin
        // flush a finished digit run ahead of this character's own token
        if (number_pending_r && ev != EV_NUM) begin
          tok0               = iel_tok(KIND_NUM, DET_NONE, number_accum_r);
          n                  = 2'd1;
          number_pending_nxt = 1'b0;
        end
        if (ev == EV_NUM && number_pending_r) begin
          number_accum_nxt = acc_sat;
        end else if (ev == EV_OTH) begin
          if (nm != 5'd0) begin
            name_match_nxt  = nm[3:0];
            error_index_nxt = char_index_r;
          end else begin
            do_fail = 1'b1;
            f_code  = S_BAD_CHAR;
            f_pos   = char_index_r;
          end
        end else begin
          apply_go = 1'b1;
        end
      end

      if (apply_go) begin
        ns = iel_next(parse_state_r, ev);
        e  = iel_err(parse_state_r, ev);
        if (ev == EV_CLOS && paren_depth_r == '0) begin
          do_fail = 1'b1;
          f_code  = S_EXTRA_CLOSE;
          f_pos   = char_index_r;
        end else if (ns == ST_ERR) begin
          do_fail = 1'b1;
          f_code  = e;
          // adjacent numbers point at the character before the second one
          f_pos   = (e == S_ADJ_NUM && char_index_r != '0) ? char_index_r - IDX_W'(1)
                                                           : char_index_r;
        end else if (ev == EV_OPEN && paren_depth_r >= PD_MAX) begin
          do_fail = 1'b1;
          f_code  = S_UNCLOSED;
          f_pos   = char_index_r;
        end else begin
          if (ev == EV_OPEN) paren_depth_nxt = paren_depth_r + PD_W'(1);
          else if (ev == EV_CLOS) paren_depth_nxt = paren_depth_r - PD_W'(1);
          parse_state_nxt = ns;
          if (ev != EV_SPACE) begin
            if (ev == EV_FUNC) begin
              tok_a  = iel_tok(KIND_FUNC, fid, '0);
              emit_a = 1'b1;
            end else if (ns == ST_SIGN) begin
              tok_a  = iel_tok(KIND_SIGN, (c == CH_MINUS) ? DET_MINUS : DET_NONE, '0);
              emit_a = 1'b1;
            end else if (ns == ST_NUM) begin
              number_pending_nxt = 1'b1;
              number_accum_nxt   = NUM_W'(c[3:0]);
            end else if (ns == ST_OPR) begin
              tok_a  = iel_tok(KIND_BINOP, op_det, '0);
              emit_a = 1'b1;
            end else begin
              tok_a  = iel_tok(KIND_PAREN, (c == CH_RPAREN) ? DET_CLOSE : DET_NONE, '0);
              emit_a = 1'b1;
            end
          end
        end
      end

      if (emit_a) begin
        if (n == 2'd0) tok0 = tok_a;
        else tok1 = tok_a;
        n = n + 2'd1;
      end

      if (do_fail) begin
        error_code_nxt  = f_code;
        error_index_nxt = f_pos;
        halted_nxt      = 1'b1;
        parse_state_nxt = ST_ERR;
        name_match_nxt  = NM_NONE;
      end

      if (eot && !halted_nxt) begin
        if (name_match_nxt != NM_NONE) begin
          error_code_nxt  = S_BAD_CHAR;
          halted_nxt      = 1'b1;
          parse_state_nxt = ST_ERR;
          name_match_nxt  = NM_NONE;
        end else begin
          if (number_pending_nxt && n != 2'd2) begin
            if (n == 2'd0) tok0 = iel_tok(KIND_NUM, DET_NONE, number_accum_nxt);
            else tok1 = iel_tok(KIND_NUM, DET_NONE, number_accum_nxt);
            n                  = n + 2'd1;
            number_pending_nxt = 1'b0;
          end
          if (parse_state_nxt == ST_OPR || parse_state_nxt == ST_SIGN)
            error_code_nxt = S_EMPTY;
          else if (paren_depth_nxt != '0)
            error_code_nxt = S_UNCLOSED;
          else
            error_code_nxt = S_OK;
          error_index_nxt = char_index_r;
        end
      end
    end

    if (step && eot) begin
      tok_end                = '0;
      tok_end.token_kind     = KIND_END;
      tok_end.check_status   = error_code_nxt;
      tok_end.error_position = error_index_nxt;
      tok_end.last_result    = 1'b1;
      // at most two words per character: the end word displaces the second one
      if (n == 2'd0) begin
        tok0 = tok_end;
        n    = 2'd1;
      end else begin
        tok1 = tok_end;
        n    = 2'd2;
      end
      parse_state_nxt    = ST_INIT;
      paren_depth_nxt    = '0;
      number_accum_nxt   = '0;
      number_pending_nxt = 1'b0;
      name_match_nxt     = NM_NONE;
      char_index_nxt     = '0;
      error_code_nxt     = S_OK;
      error_index_nxt    = '0;
      halted_nxt         = 1'b0;
    end
  end

  assign push.cnt  = n;
  assign push.tok0 = tok0;
  assign push.tok1 = tok1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_state_r    <= ST_INIT;
      paren_depth_r    <= '0;
      number_accum_r   <= '0;
      number_pending_r <= 1'b0;
      name_match_r     <= NM_NONE;
      char_index_r     <= '0;
      error_code_r     <= S_OK;
      error_index_r    <= '0;
      halted_r         <= 1'b0;
    end else begin
      parse_state_r    <= parse_state_nxt;
      paren_depth_r    <= paren_depth_nxt;
      number_accum_r   <= number_accum_nxt;
      number_pending_r <= number_pending_nxt;
      name_match_r     <= name_match_nxt;
      char_index_r     <= char_index_nxt;
      error_code_r     <= error_code_nxt;
      error_index_r    <= error_index_nxt;
      halted_r         <= halted_nxt;
    end
  end

  a_halt_err: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> parse_state_r == ST_ERR)
    else $error("halted without error state");

  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    parse_state_r == ST_ERR |-> halted_r)
    else $error("error state without halt");

  a_name_no_num: assert property (@(posedge clk) disable iff (!rst_n)
    name_match_r != NM_NONE |-> !number_pending_r)
    else $error("name match while a number is pending");

  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && eot) |=> (char_index_r == '0 && !halted_r && paren_depth_r == '0))
    else $error("state not cleared after end of text");

endmodule

@@ design/iel_token_fifo.sv @@
`timescale 1ns / 1ps

module iel_token_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  iel_pkg::push_t     push,
  output logic               almost_full,
  output logic               out_valid,
  input  logic               out_stall,
  output iel_pkg::out_word_t out_word
);
  import iel_pkg::*;

  localparam logic [TQ_CW-1:0] Q_HIGH = TQ_CW'(TQ_DEPTH - 2);

  out_word_t        mem_r [TQ_DEPTH];
  logic [TQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [TQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [TQ_CW-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid   = (count_r != '0);
  assign out_word    = mem_r[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  // keep room for two words from the next character
  assign almost_full = (count_r > Q_HIGH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + TQ_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + TQ_AW'(pop);
    count_nxt  = count_r + TQ_CW'(push.cnt) - TQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + TQ_AW'(1)] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r <= Q_HIGH)
    else $error("push into token queue without room");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TQ_CW'(TQ_DEPTH))
    else $error("token queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    TQ_AW'(wr_ptr_r - rd_ptr_r) == count_r[TQ_AW-1:0])
    else $error("token queue pointers disagree with count");

endmodule

@@ design/infix_expression_lexer_checker_unit.sv @@
`timescale 1ns / 1ps

// Infix expression lexer and checker.
// Input channel (in_valid / in_stall / in_word): one ASCII character per word,
// with end_of_text set on the last character of an expression.
// Output channel (out_valid / out_stall / out_word): token words in order:
// numbers, signs, binary operators, functions, parentheses, and one end word
// (last_result = 1) per expression carrying check_status and error_position.
// A character's tokens are written into a registered token queue when it is
// accepted. Throughput: one character per cycle while the output keeps up.
// A character that closes a digit run and has a token of its own, or the
// final character, can yield two words; the output then drains one word per
// cycle while out_stall is low from a four-word token queue, and in_stall
// rises while more than two words wait in it.
// Reset clears the parser state and empties the queue; the next character
// is the first of a new expression. After each end word the parser also
// returns to its reset state. While out_stall is high the queued words hold
// and input is taken until the queue nears full.
module infix_expression_lexer_checker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iel_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output iel_pkg::out_word_t out_word
);
  import iel_pkg::*;

  push_t push;
  logic  step;
  logic  almost_full;

  assign in_stall = almost_full;
  assign step     = in_valid && !almost_full;

  iel_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word),
    .push    (push)
  );

  iel_token_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .almost_full (almost_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule
